### hw/rtl/ccs_pkg.sv
// Package for the chamber cycle sequencer: step and door codes, register
// indexes, register reset values, drive bit positions and announcement codes.
// No dependencies.
package ccs_pkg;

    localparam int NUM_CFG        = 8;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DRIVE_BITS     = 6;
    localparam int VOICE_BITS     = 5;

    typedef enum logic [2:0] {
        STEP_IDLE     = 3'd0,
        STEP_SETTLE   = 3'd1,
        STEP_CLOSE    = 3'd2,
        STEP_PRESSURE = 3'd3,
        STEP_OXYGEN   = 3'd4,
        STEP_EXHAUST  = 3'd5,
        STEP_OPEN     = 3'd6,
        STEP_FINISH   = 3'd7
    } step_t;

    typedef enum logic [1:0] {
        DOOR_NONE  = 2'd0,
        DOOR_CLOSE = 2'd1,
        DOOR_OPEN  = 2'd2
    } door_t;

    localparam logic [2:0] CFG_DOOR_DELAY = 3'd0;
    localparam logic [2:0] CFG_SETTLE     = 3'd1;
    localparam logic [2:0] CFG_CLOSE_WAIT = 3'd2;
    localparam logic [2:0] CFG_CLOSE_DONE = 3'd3;
    localparam logic [2:0] CFG_PRESSURE   = 3'd4;
    localparam logic [2:0] CFG_HEAT       = 3'd5;
    localparam logic [2:0] CFG_OXYGEN     = 3'd6;
    localparam logic [2:0] CFG_EXHAUST    = 3'd7;

    localparam logic [CFG_DATA_BITS-1:0] CFG_RESET [NUM_CFG] = '{
        16'd3000, 16'd3000, 16'd4000, 16'd10000,
        16'd4000, 16'd8000, 16'd2000, 16'd2000
    };

    localparam int DRV_CLOSE = 0;
    localparam int DRV_OPEN  = 1;
    localparam int DRV_PRESS = 2;
    localparam int DRV_EXH   = 3;
    localparam int DRV_HEAT  = 4;
    localparam int DRV_OXY   = 5;

    localparam int CMD_START     = 0;
    localparam int CMD_STOP      = 1;
    localparam int CMD_HEAT_ON   = 2;
    localparam int CMD_HEAT_OFF  = 3;
    localparam int CMD_PRESS_ON  = 4;
    localparam int CMD_PRESS_OFF = 5;
    localparam int CMD_EXH_ON    = 6;
    localparam int CMD_EXH_OFF   = 7;

    localparam int CMDB_OXY_ON  = 0;
    localparam int CMDB_OXY_OFF = 1;
    localparam int CMDB_CLOSE   = 2;
    localparam int CMDB_OPEN    = 3;

    localparam logic [VOICE_BITS-1:0] VOICE_NONE      = 5'd0;
    localparam logic [VOICE_BITS-1:0] VOICE_SETTLE    = 5'd1;
    localparam logic [VOICE_BITS-1:0] VOICE_STOP      = 5'd8;
    localparam logic [VOICE_BITS-1:0] VOICE_DOOR_OPEN = 5'd10;
    localparam logic [VOICE_BITS-1:0] VOICE_DOOR_CLS  = 5'd11;
    localparam logic [VOICE_BITS-1:0] VOICE_PRESS_ON  = 5'd12;
    localparam logic [VOICE_BITS-1:0] VOICE_PRESS_OFF = 5'd13;
    localparam logic [VOICE_BITS-1:0] VOICE_EXH_ON    = 5'd14;
    localparam logic [VOICE_BITS-1:0] VOICE_EXH_OFF   = 5'd15;
    localparam logic [VOICE_BITS-1:0] VOICE_HEAT_ON   = 5'd16;
    localparam logic [VOICE_BITS-1:0] VOICE_HEAT_OFF  = 5'd17;
    localparam logic [VOICE_BITS-1:0] VOICE_OXY_ON    = 5'd18;
    localparam logic [VOICE_BITS-1:0] VOICE_OXY_OFF   = 5'd19;

endpackage

### hw/rtl/chamber_cycle_sequencer.sv
// Chamber cycle sequencer top level: scan input register, per-scan control
// logic and result register. Depends on ccs_pkg.
//
// Usage: one beat on the scan channel is one control scan (two command words,
// digital inputs, milliseconds elapsed). Each scan yields exactly one beat on
// the result channel: drive outputs, cycle step and the announcement of the
// scan. A beat moves when its valid is high and its stall is low.
// A scan taken passes the scan register, then the result register.
// Throughput: one scan per cycle while the result side does not stall; the
// scan register feeds the result register through one pass of control
// logic, and the state updates at the moment the result register loads.
// When the result side stalls, the result register holds; the scan register
// still takes one more beat, then scan_stall rises until the result moves.
// Reset clears both valid flags and the control state, and loads the
// timing registers with their default values. The user must write the
// timing registers through cfg_we/cfg_index/cfg_wdata only while no scan is
// in flight (not enforced); an index beyond the last register is ignored.
module chamber_cycle_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ccs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ccs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                scan_valid,
    output logic                                scan_stall,
    input  logic [7:0]                          cmd_word_a,
    input  logic [3:0]                          cmd_word_b,
    input  logic [7:0]                          digital_in,
    input  logic [9:0]                          elapsed_ms,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [ccs_pkg::DRIVE_BITS-1:0]      drive_bits,
    output logic [2:0]                          step_code,
    output logic                                voice_valid,
    output logic [ccs_pkg::VOICE_BITS-1:0]      voice_number
);

    localparam int CMP_BITS = (TIMER_BITS > ccs_pkg::CFG_DATA_BITS) ?
                              TIMER_BITS : ccs_pkg::CFG_DATA_BITS;

    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [9:0]            d
    );
        logic [TIMER_BITS:0] sum;
        sum = {1'b0, t} + (TIMER_BITS+1)'(d);
        return sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
    endfunction

    logic [ccs_pkg::CFG_DATA_BITS-1:0] cfg_reg [ccs_pkg::NUM_CFG];

    logic                          scan_valid_reg;
    logic [7:0]                    cmd_a_reg;
    logic [3:0]                    cmd_b_reg;
    logic [1:0]                    din_reg;
    logic [9:0]                    elapsed_reg;

    ccs_pkg::step_t                step_reg, step_next;
    logic [ccs_pkg::DRIVE_BITS-1:0] drive_reg, drive_next;
    logic [TIMER_BITS-1:0]         step_timer_reg, step_timer_next;
    logic                          step_fresh_reg, step_fresh_next;
    ccs_pkg::door_t                door_pending_reg, door_pending_next;
    logic [TIMER_BITS-1:0]         door_timer_reg, door_timer_next;
    logic [3:0]                    last_cmd_b_reg, last_cmd_b_next;

    logic                          res_valid_reg;
    logic [ccs_pkg::DRIVE_BITS-1:0] res_drive_reg;
    logic [2:0]                    res_step_reg;
    logic                          res_voice_ok_reg;
    logic [ccs_pkg::VOICE_BITS-1:0] res_voice_no_reg;

    logic                          voice_ok_next;
    logic [ccs_pkg::VOICE_BITS-1:0] voice_no_next;

    logic                          advance;
    logic                          scan_take;
    logic                          stop_cmd;
    logic                          start_cmd;
    logic                          is_idle;
    logic [TIMER_BITS-1:0]         door_timer_aged;
    ccs_pkg::door_t                door_pend_aged;
    logic [TIMER_BITS-1:0]         step_timer_run;
    logic [ccs_pkg::NUM_CFG-1:0]   step_ge;
    logic                          door_ge_aged;

    assign advance    = scan_valid_reg && (!res_valid_reg || !result_stall);
    assign scan_stall = scan_valid_reg && !advance;
    assign scan_take  = scan_valid && !scan_stall;

    assign result_valid = res_valid_reg;
    assign drive_bits   = res_drive_reg;
    assign step_code    = res_step_reg;
    assign voice_valid  = res_voice_ok_reg;
    assign voice_number = res_voice_no_reg;

    // Shared terms: commands, aged timers, threshold compares
    always_comb
    begin
        stop_cmd  = cmd_a_reg[ccs_pkg::CMD_STOP] || din_reg[ccs_pkg::CMD_STOP];
        start_cmd = cmd_a_reg[ccs_pkg::CMD_START] || din_reg[ccs_pkg::CMD_START];
        is_idle   = (step_reg == ccs_pkg::STEP_IDLE);

        if (door_pending_reg == ccs_pkg::DOOR_CLOSE || door_pending_reg == ccs_pkg::DOOR_OPEN)
        begin
            door_timer_aged = sat_add(door_timer_reg, elapsed_reg);
            door_pend_aged  = door_pending_reg;
        end
        else
        begin
            door_timer_aged = door_timer_reg;
            door_pend_aged  = ccs_pkg::DOOR_NONE;
        end

        step_timer_run = step_fresh_reg ? '0 : sat_add(step_timer_reg, elapsed_reg);

        for (int i = 0; i < ccs_pkg::NUM_CFG; i++)
        begin
            step_ge[i] = CMP_BITS'(step_timer_run) >= CMP_BITS'(cfg_reg[i]);
        end
        door_ge_aged = CMP_BITS'(door_timer_aged) >=
                       CMP_BITS'(cfg_reg[ccs_pkg::CFG_DOOR_DELAY]);
    end

    // Next step, step timer and fresh flag
    always_comb
    begin
        step_next       = step_reg;
        step_timer_next = step_timer_reg;
        step_fresh_next = step_fresh_reg;
        if (is_idle)
        begin
            if (start_cmd)
            begin
                step_next       = ccs_pkg::STEP_SETTLE;
                step_fresh_next = 1'b1;
            end
        end
        else if (stop_cmd)
        begin
            step_next       = ccs_pkg::STEP_IDLE;
            step_fresh_next = 1'b1;
        end
        else
        begin
            step_timer_next = step_timer_run;
            step_fresh_next = 1'b0;
            unique case (step_reg)
                ccs_pkg::STEP_SETTLE:
                begin
                    if (step_ge[ccs_pkg::CFG_SETTLE])
                    begin
                        step_next       = ccs_pkg::STEP_CLOSE;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_CLOSE:
                begin
                    if (step_ge[ccs_pkg::CFG_CLOSE_DONE])
                    begin
                        step_next       = ccs_pkg::STEP_PRESSURE;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_PRESSURE:
                begin
                    if (step_ge[ccs_pkg::CFG_HEAT])
                    begin
                        step_next       = ccs_pkg::STEP_OXYGEN;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_OXYGEN:
                begin
                    if (step_ge[ccs_pkg::CFG_OXYGEN])
                    begin
                        step_next       = ccs_pkg::STEP_EXHAUST;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_EXHAUST:
                begin
                    if (step_ge[ccs_pkg::CFG_EXHAUST])
                    begin
                        step_next       = ccs_pkg::STEP_OPEN;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_OPEN:
                begin
                    if (step_ge[ccs_pkg::CFG_DOOR_DELAY])
                    begin
                        step_next       = ccs_pkg::STEP_FINISH;
                        step_fresh_next = 1'b1;
                    end
                end
                ccs_pkg::STEP_FINISH, ccs_pkg::STEP_IDLE:
                begin
                    step_next       = ccs_pkg::STEP_IDLE;
                    step_fresh_next = 1'b1;
                end
            endcase
        end
    end

    // Drives, door handling and announcement
    always_comb
    begin
        logic [3:0] rise;
        logic       door_ge;
        drive_next        = drive_reg;
        voice_ok_next     = 1'b0;
        voice_no_next     = ccs_pkg::VOICE_NONE;
        door_pending_next = door_pend_aged;
        door_timer_next   = door_timer_aged;
        last_cmd_b_next   = last_cmd_b_reg;
        rise              = cmd_b_reg & ~last_cmd_b_reg;
        door_ge           = door_ge_aged;

        if (is_idle)
        begin
            if (rise[ccs_pkg::CMDB_CLOSE])
            begin
                voice_ok_next     = 1'b1;
                voice_no_next     = ccs_pkg::VOICE_DOOR_CLS;
                door_pending_next = ccs_pkg::DOOR_CLOSE;
                door_timer_next   = '0;
            end
            if (rise[ccs_pkg::CMDB_OPEN])
            begin
                voice_ok_next     = 1'b1;
                voice_no_next     = ccs_pkg::VOICE_DOOR_OPEN;
                door_pending_next = ccs_pkg::DOOR_OPEN;
                door_timer_next   = '0;
            end
            if (rise[ccs_pkg::CMDB_CLOSE] || rise[ccs_pkg::CMDB_OPEN])
            begin
                door_ge = (cfg_reg[ccs_pkg::CFG_DOOR_DELAY] == '0);
            end
            if (door_pending_next == ccs_pkg::DOOR_CLOSE && door_ge)
            begin
                drive_next[ccs_pkg::DRV_CLOSE] = 1'b1;
                drive_next[ccs_pkg::DRV_OPEN]  = 1'b0;
                door_pending_next = ccs_pkg::DOOR_NONE;
            end
            else if (door_pending_next == ccs_pkg::DOOR_OPEN && door_ge)
            begin
                drive_next[ccs_pkg::DRV_OPEN]  = 1'b1;
                drive_next[ccs_pkg::DRV_CLOSE] = 1'b0;
                door_pending_next = ccs_pkg::DOOR_NONE;
            end
            last_cmd_b_next = cmd_b_reg;

            if (cmd_a_reg[ccs_pkg::CMD_PRESS_ON])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_PRESS_ON;
                drive_next[ccs_pkg::DRV_PRESS] = 1'b1;
            end
            else if (cmd_a_reg[ccs_pkg::CMD_PRESS_OFF])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_PRESS_OFF;
                drive_next[ccs_pkg::DRV_PRESS] = 1'b0;
            end
            if (cmd_a_reg[ccs_pkg::CMD_EXH_ON])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_EXH_ON;
                drive_next[ccs_pkg::DRV_EXH] = 1'b1;
            end
            else if (cmd_a_reg[ccs_pkg::CMD_EXH_OFF])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_EXH_OFF;
                drive_next[ccs_pkg::DRV_EXH] = 1'b0;
            end
            if (cmd_a_reg[ccs_pkg::CMD_HEAT_ON])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_HEAT_ON;
                drive_next[ccs_pkg::DRV_HEAT] = 1'b1;
            end
            else if (cmd_a_reg[ccs_pkg::CMD_HEAT_OFF])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_HEAT_OFF;
                drive_next[ccs_pkg::DRV_HEAT] = 1'b0;
            end
            if (cmd_b_reg[ccs_pkg::CMDB_OXY_ON])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_OXY_ON;
                drive_next[ccs_pkg::DRV_OXY] = 1'b1;
            end
            else if (cmd_b_reg[ccs_pkg::CMDB_OXY_OFF])
            begin
                voice_ok_next = 1'b1;
                voice_no_next = ccs_pkg::VOICE_OXY_OFF;
                drive_next[ccs_pkg::DRV_OXY] = 1'b0;
            end
        end
        else if (stop_cmd)
        begin
            voice_ok_next = 1'b1;
            voice_no_next = ccs_pkg::VOICE_STOP;
        end
        else
        begin
            voice_ok_next = 1'b1;
            unique case (step_reg)
                ccs_pkg::STEP_SETTLE:
                begin
                    drive_next    = '0;
                    voice_no_next = ccs_pkg::VOICE_SETTLE;
                end
                ccs_pkg::STEP_CLOSE:
                begin
                    voice_no_next = ccs_pkg::VOICE_DOOR_CLS;
                    if (step_ge[ccs_pkg::CFG_CLOSE_WAIT])
                    begin
                        drive_next[ccs_pkg::DRV_CLOSE] = 1'b1;
                        drive_next[ccs_pkg::DRV_OPEN]  = 1'b0;
                    end
                end
                ccs_pkg::STEP_PRESSURE:
                begin
                    voice_no_next = ccs_pkg::VOICE_PRESS_ON;
                    if (step_ge[ccs_pkg::CFG_PRESSURE])
                    begin
                        drive_next[ccs_pkg::DRV_PRESS] = 1'b1;
                        voice_no_next = ccs_pkg::VOICE_HEAT_ON;
                    end
                    if (step_ge[ccs_pkg::CFG_HEAT])
                    begin
                        drive_next[ccs_pkg::DRV_HEAT] = 1'b1;
                    end
                end
                ccs_pkg::STEP_OXYGEN:
                begin
                    voice_no_next = ccs_pkg::VOICE_OXY_ON;
                    if (step_ge[ccs_pkg::CFG_OXYGEN])
                    begin
                        drive_next[ccs_pkg::DRV_OXY] = 1'b1;
                    end
                end
                ccs_pkg::STEP_EXHAUST:
                begin
                    voice_no_next = ccs_pkg::VOICE_EXH_ON;
                    if (step_ge[ccs_pkg::CFG_EXHAUST])
                    begin
                        drive_next[ccs_pkg::DRV_EXH] = 1'b1;
                    end
                end
                ccs_pkg::STEP_OPEN:
                begin
                    voice_no_next = ccs_pkg::VOICE_DOOR_OPEN;
                    if (step_ge[ccs_pkg::CFG_DOOR_DELAY])
                    begin
                        drive_next[ccs_pkg::DRV_OPEN]  = 1'b1;
                        drive_next[ccs_pkg::DRV_CLOSE] = 1'b0;
                    end
                end
                ccs_pkg::STEP_FINISH, ccs_pkg::STEP_IDLE:
                begin
                    voice_no_next = ccs_pkg::VOICE_STOP;
                    drive_next[ccs_pkg::DRV_PRESS] = 1'b0;
                    drive_next[ccs_pkg::DRV_EXH]   = 1'b0;
                    drive_next[ccs_pkg::DRV_HEAT]  = 1'b0;
                    drive_next[ccs_pkg::DRV_OXY]   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccs_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= ccs_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we && cfg_index < ccs_pkg::CFG_IDX_BITS'(ccs_pkg::NUM_CFG))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_take)
        begin
            scan_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            scan_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            cmd_a_reg   <= cmd_word_a;
            cmd_b_reg   <= cmd_word_b;
            din_reg     <= digital_in[1:0];
            elapsed_reg <= elapsed_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= ccs_pkg::STEP_IDLE;
            drive_reg        <= '0;
            step_timer_reg   <= '0;
            step_fresh_reg   <= 1'b1;
            door_pending_reg <= ccs_pkg::DOOR_NONE;
            door_timer_reg   <= '0;
            last_cmd_b_reg   <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg         <= step_next;
                drive_reg        <= drive_next;
                step_timer_reg   <= step_timer_next;
                step_fresh_reg   <= step_fresh_next;
                door_pending_reg <= door_pending_next;
                door_timer_reg   <= door_timer_next;
                last_cmd_b_reg   <= last_cmd_b_next;
                res_valid_reg    <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_drive_reg    <= drive_next;
            res_step_reg     <= step_next;
            res_voice_ok_reg <= voice_ok_next;
            res_voice_no_reg <= voice_no_next;
        end
    end

endmodule

### hw/rtl/ccs_checker.sv
// Port-level checker for the chamber cycle sequencer, bound to the top level.
// Depends on ccs_pkg for field widths, drive bit positions and VOICE_NONE.
module ccs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               scan_stall,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [ccs_pkg::DRIVE_BITS-1:0]     drive_bits,
    input logic [2:0]                         step_code,
    input logic                               voice_valid,
    input logic [ccs_pkg::VOICE_BITS-1:0]     voice_number
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(drive_bits)
            && $stable(step_code) && $stable(voice_valid) && $stable(voice_number))
        else $error("stalled result beat changed");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !scan_stall)
        else $error("scan stalled while result register empty");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !voice_valid |-> voice_number == ccs_pkg::VOICE_NONE)
        else $error("announcement number without announcement");

    a_door_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(drive_bits[ccs_pkg::DRV_CLOSE] && drive_bits[ccs_pkg::DRV_OPEN]))
        else $error("door close and open driven together");

endmodule

bind chamber_cycle_sequencer ccs_checker u_ccs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_stall   (scan_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive_bits   (drive_bits),
    .step_code    (step_code),
    .voice_valid  (voice_valid),
    .voice_number (voice_number)
);

### sim/tb_top.sv
// Testbench for chamber_cycle_sequencer: directed scan table, then random phases over
// several timing settings; result beats checked vs. table or an in-bench scan predictor.
// Depends on ccs_pkg and the chamber_cycle_sequencer RTL.
module tb_top;
    import ccs_pkg::*;

    localparam int TIMER_W     = 16;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int DIR_ROWS    = 25;
    localparam int NUM_PHASES  = 5;

    localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 200, 450, 250, 250};
    localparam int PHASE_STOP  [NUM_PHASES] = '{20, 30, 1, 15, 10};
    localparam int PHASE_EL_LO [NUM_PHASES] = '{0, 0, 900, 0, 512};

    typedef struct packed {
        logic [5:0] drive;
        step_t      step;
        logic       vv;
        logic [4:0] vn;
    } scan_result_t;

    typedef struct packed {
        logic [7:0]   cmd_a;
        logic [3:0]   cmd_b;
        logic [7:0]   din;
        logic [9:0]   el;
        logic         typed;
        scan_result_t want;
    } scan_row_t;

    localparam scan_result_t NO_WANT = '{6'd0, STEP_IDLE, 1'b0, VOICE_NONE};

    localparam scan_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h00, 4'h0, 8'h00, 10'd0,    1'b1, '{6'd0, STEP_IDLE, 1'b0, VOICE_NONE}},
        '{8'h30, 4'h0, 8'h00, 10'd5,    1'b1,
            '{6'(1 << DRV_PRESS), STEP_IDLE, 1'b1, VOICE_PRESS_ON}},
        '{8'hC0, 4'h0, 8'h00, 10'd5,    1'b1,
            '{6'((1 << DRV_PRESS) | (1 << DRV_EXH)), STEP_IDLE, 1'b1, VOICE_EXH_ON}},
        '{8'h0C, 4'h0, 8'h00, 10'd5,    1'b1,
            '{6'((1 << DRV_PRESS) | (1 << DRV_EXH) | (1 << DRV_HEAT)),
              STEP_IDLE, 1'b1, VOICE_HEAT_ON}},
        '{8'h00, 4'h3, 8'h00, 10'd5,    1'b1,
            '{6'((1 << DRV_PRESS) | (1 << DRV_EXH) | (1 << DRV_HEAT) | (1 << DRV_OXY)),
              STEP_IDLE, 1'b1, VOICE_OXY_ON}},
        '{8'hA8, 4'h2, 8'h00, 10'd5,    1'b1, '{6'd0, STEP_IDLE, 1'b1, VOICE_OXY_OFF}},
        '{8'h00, 4'hC, 8'h00, 10'd0,    1'b1, '{6'd0, STEP_IDLE, 1'b1, VOICE_DOOR_OPEN}},
        '{8'h00, 4'hC, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'hC, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h8, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h4, 8'h00, 10'd100,  1'b1,
            '{6'(1 << DRV_OPEN), STEP_IDLE, 1'b1, VOICE_DOOR_CLS}},
        '{8'h00, 4'h4, 8'h01, 10'd1023, 1'b0, NO_WANT},
        '{8'h01, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'hFE, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd0,    1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'hFF, 10'd1023, 1'b0, NO_WANT},
        '{8'hFF, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'hFF, 4'hF, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h00, 10'd1023, 1'b0, NO_WANT},
        '{8'h00, 4'h0, 8'h02, 10'd1023, 1'b0, NO_WANT}
    };

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata    = '0;
    logic                     scan_valid   = 1'b0;
    logic                     scan_stall;
    logic [7:0]               cmd_word_a   = '0;
    logic [3:0]               cmd_word_b   = '0;
    logic [7:0]               digital_in   = '0;
    logic [9:0]               elapsed_ms   = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [DRIVE_BITS-1:0]    drive_bits;
    logic [2:0]               step_code;
    logic                     voice_valid;
    logic [VOICE_BITS-1:0]    voice_number;

    logic [15:0]        timing [NUM_CFG];
    step_t              seq_step;
    logic [5:0]         drv;
    logic [TIMER_W-1:0] step_tmr;
    logic               step_fresh;
    door_t              door_pend;
    logic [TIMER_W-1:0] door_tmr;
    logic [3:0]         last_b;
    logic               say_valid;
    logic [4:0]         say_num;

    scan_result_t outcome_q [$];
    int           fail_count   = 0;
    int           cycle_count  = 0;
    bit           no_idle      = 1'b0;
    bit           hold_pending = 1'b0;
    int           burst_left   = 0;

    chamber_cycle_sequencer #(.TIMER_BITS(TIMER_W)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .cmd_word_a   (cmd_word_a),
        .cmd_word_b   (cmd_word_b),
        .digital_in   (digital_in),
        .elapsed_ms   (elapsed_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive_bits   (drive_bits),
        .step_code    (step_code),
        .voice_valid  (voice_valid),
        .voice_number (voice_number)
    );

    always #6 clk = ~clk;

    function automatic logic [TIMER_W-1:0] tmr_add(input logic [TIMER_W-1:0] t,
                                                   input logic [9:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + d;
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    function automatic void announce(input logic [4:0] n);
        say_valid = 1'b1;
        say_num   = n;
    endfunction

    function automatic scan_result_t scan_outcome(input logic [7:0] a, input logic [3:0] b,
                                                  input logic [7:0] din, input logic [9:0] el);
        logic [3:0] rise;
        say_valid = 1'b0;
        say_num   = VOICE_NONE;
        if (door_pend != DOOR_NONE)
            door_tmr = tmr_add(door_tmr, el);
        if (seq_step == STEP_IDLE)
        begin
            rise = b & ~last_b;
            if (rise[CMDB_CLOSE])
            begin
                announce(VOICE_DOOR_CLS);
                door_pend = DOOR_CLOSE;
                door_tmr  = '0;
            end
            if (rise[CMDB_OPEN])
            begin
                announce(VOICE_DOOR_OPEN);
                door_pend = DOOR_OPEN;
                door_tmr  = '0;
            end
            if (door_pend == DOOR_CLOSE && door_tmr >= timing[CFG_DOOR_DELAY])
            begin
                drv[DRV_CLOSE] = 1'b1;
                drv[DRV_OPEN]  = 1'b0;
                door_pend      = DOOR_NONE;
            end
            else if (door_pend == DOOR_OPEN && door_tmr >= timing[CFG_DOOR_DELAY])
            begin
                drv[DRV_OPEN]  = 1'b1;
                drv[DRV_CLOSE] = 1'b0;
                door_pend      = DOOR_NONE;
            end
            last_b = b;
            if (a[CMD_PRESS_ON])
            begin
                announce(VOICE_PRESS_ON);
                drv[DRV_PRESS] = 1'b1;
            end
            else if (a[CMD_PRESS_OFF])
            begin
                announce(VOICE_PRESS_OFF);
                drv[DRV_PRESS] = 1'b0;
            end
            if (a[CMD_EXH_ON])
            begin
                announce(VOICE_EXH_ON);
                drv[DRV_EXH] = 1'b1;
            end
            else if (a[CMD_EXH_OFF])
            begin
                announce(VOICE_EXH_OFF);
                drv[DRV_EXH] = 1'b0;
            end
            if (a[CMD_HEAT_ON])
            begin
                announce(VOICE_HEAT_ON);
                drv[DRV_HEAT] = 1'b1;
            end
            else if (a[CMD_HEAT_OFF])
            begin
                announce(VOICE_HEAT_OFF);
                drv[DRV_HEAT] = 1'b0;
            end
            if (b[CMDB_OXY_ON])
            begin
                announce(VOICE_OXY_ON);
                drv[DRV_OXY] = 1'b1;
            end
            else if (b[CMDB_OXY_OFF])
            begin
                announce(VOICE_OXY_OFF);
                drv[DRV_OXY] = 1'b0;
            end
            if (a[CMD_START] || din[CMD_START])
            begin
                seq_step   = STEP_SETTLE;
                step_fresh = 1'b1;
            end
        end
        else if (a[CMD_STOP] || din[CMD_STOP])
        begin
            seq_step   = STEP_IDLE;
            step_fresh = 1'b1;
            announce(VOICE_STOP);
        end
        else
        begin
            if (step_fresh)
            begin
                step_tmr   = '0;
                step_fresh = 1'b0;
            end
            else
                step_tmr = tmr_add(step_tmr, el);
            case (seq_step)
                STEP_SETTLE:
                begin
                    drv = '0;
                    if (step_tmr >= timing[CFG_SETTLE])
                    begin
                        seq_step   = STEP_CLOSE;
                        step_fresh = 1'b1;
                    end
                    announce(VOICE_SETTLE);
                end
                STEP_CLOSE:
                begin
                    announce(VOICE_DOOR_CLS);
                    if (step_tmr >= timing[CFG_CLOSE_WAIT])
                    begin
                        drv[DRV_CLOSE] = 1'b1;
                        drv[DRV_OPEN]  = 1'b0;
                    end
                    if (step_tmr >= timing[CFG_CLOSE_DONE])
                    begin
                        seq_step   = STEP_PRESSURE;
                        step_fresh = 1'b1;
                    end
                end
                STEP_PRESSURE:
                begin
                    announce(VOICE_PRESS_ON);
                    if (step_tmr >= timing[CFG_PRESSURE])
                    begin
                        drv[DRV_PRESS] = 1'b1;
                        announce(VOICE_HEAT_ON);
                    end
                    if (step_tmr >= timing[CFG_HEAT])
                    begin
                        drv[DRV_HEAT] = 1'b1;
                        seq_step      = STEP_OXYGEN;
                        step_fresh    = 1'b1;
                    end
                end
                STEP_OXYGEN:
                begin
                    announce(VOICE_OXY_ON);
                    if (step_tmr >= timing[CFG_OXYGEN])
                    begin
                        drv[DRV_OXY] = 1'b1;
                        seq_step     = STEP_EXHAUST;
                        step_fresh   = 1'b1;
                    end
                end
                STEP_EXHAUST:
                begin
                    announce(VOICE_EXH_ON);
                    if (step_tmr >= timing[CFG_EXHAUST])
                    begin
                        drv[DRV_EXH] = 1'b1;
                        seq_step     = STEP_OPEN;
                        step_fresh   = 1'b1;
                    end
                end
                STEP_OPEN:
                begin
                    announce(VOICE_DOOR_OPEN);
                    if (step_tmr >= timing[CFG_DOOR_DELAY])
                    begin
                        drv[DRV_OPEN]  = 1'b1;
                        drv[DRV_CLOSE] = 1'b0;
                        seq_step       = STEP_FINISH;
                        step_fresh     = 1'b1;
                    end
                end
                default:
                begin
                    drv        = drv & 6'((1 << DRV_CLOSE) | (1 << DRV_OPEN));
                    seq_step   = STEP_IDLE;
                    step_fresh = 1'b1;
                    announce(VOICE_STOP);
                end
            endcase
        end
        return '{drv, seq_step, say_valid, say_num};
    endfunction

    task automatic pick_scan(input int stop_rate, input int el_floor,
                             output logic [7:0] a, output logic [3:0] b,
                             output logic [7:0] din, output logic [9:0] el);
        a   = 8'($urandom);
        b   = 4'($urandom);
        din = 8'($urandom);
        el  = 10'($urandom_range(el_floor, 1023));
        if (seq_step == STEP_IDLE)
        begin
            a[CMD_START]   = ($urandom_range(0, 3) == 0);
            din[CMD_START] = ($urandom_range(0, 7) == 0);
        end
        else if ($urandom_range(0, 999) >= stop_rate)
        begin
            a[CMD_STOP]   = 1'b0;
            din[CMD_STOP] = 1'b0;
        end
    endtask

    task automatic send_scan(input logic [7:0] a, input logic [3:0] b,
                             input logic [7:0] din, input logic [9:0] el,
                             input logic typed, input scan_result_t want);
        int           gap;
        scan_result_t predicted;
        gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, 14);
        if (burst_left > 0)
            burst_left--;
        if (gap != 0)
        begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_valid <= 1'b1;
        cmd_word_a <= a;
        cmd_word_b <= b;
        digital_in <= din;
        elapsed_ms <= el;
        do
            @(posedge clk);
        while (scan_stall);
        predicted = scan_outcome(a, b, din, el);
        outcome_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        scan_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timing(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NUM_CFG)
            timing[idx[2:0]] = val;
    endtask

    initial
    begin : stimulus
        logic [7:0]  a;
        logic [3:0]  b;
        logic [7:0]  din;
        logic [9:0]  el;
        logic [15:0] val;
        for (int i = 0; i < NUM_CFG; i++)
            timing[i] = CFG_RESET[i];
        seq_step   = STEP_IDLE;
        drv        = '0;
        step_tmr   = '0;
        step_fresh = 1'b1;
        door_pend  = DOOR_NONE;
        door_tmr   = '0;
        last_b     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_scan(DIRECTED[i].cmd_a, DIRECTED[i].cmd_b, DIRECTED[i].din,
                      DIRECTED[i].el, DIRECTED[i].typed, DIRECTED[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            if (ph != 0)
            begin
                for (int r = 0; r < NUM_CFG; r++)
                begin
                    case (ph)
                        1: val = 16'd0;
                        2: val = 16'hFFFF;
                        3: val = 16'($urandom_range(0, 2000));
                        default:
                            case ($urandom_range(0, 3))
                                0: val = 16'd0;
                                1: val = 16'hFFFF;
                                default: val = 16'($urandom_range(0, 4000));
                            endcase
                    endcase
                    write_timing(CFG_IDX_BITS'(r), val);
                end
                write_timing(CFG_IDX_BITS'(NUM_CFG + $urandom_range(0, 7)), 16'($urandom));
                cfg_we <= 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS[ph]; k++)
            begin
                no_idle = (k >= 30 && k < 60);
                if (ph == 2 && k == 100)
                begin
                    hold_pending = 1'b1;
                    burst_left   = 24;
                end
                if (ph == 3 && k == 125)
                    drain_results();
                pick_scan(PHASE_STOP[ph], PHASE_EL_LO[ph], a, b, din, el);
                send_scan(a, b, din, el, 1'b0, NO_WANT);
            end
        end

        no_idle = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        int n;
        forever
        begin
            if (hold_pending)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            n = no_idle ? 0 : $urandom_range(0, 14);
            if (n != 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        scan_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result beat with no scan outstanding");
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (drive_bits !== want.drive)
                begin
                    $error("drive_bits: expected %h, got %h", want.drive, drive_bits);
                    fail_count++;
                end
                if (step_code !== want.step)
                begin
                    $error("step_code: expected %0d, got %0d", want.step, step_code);
                    fail_count++;
                end
                if (voice_valid !== want.vv)
                begin
                    $error("voice_valid: expected %0d, got %0d", want.vv, voice_valid);
                    fail_count++;
                end
                if (voice_number !== want.vn)
                begin
                    $error("voice_number: expected %0d, got %0d", want.vn, voice_number);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
